>>> src/edtd_pkg.sv
// ----------------------------------------------------------------------------
// EDID detailed timing decoder package
// Shared widths, register map, reset values and the decoded timing record.
// ----------------------------------------------------------------------------
package edtd_pkg;

	localparam int DESCRIPTOR_LENGTH = 18;
	localparam int POS_W             = 5;

	localparam int CLOCK_W    = 20;
	localparam int ACTIVE_W   = 12;
	localparam int TOTAL_W    = 13;
	localparam int QUOTIENT_W = 30;
	localparam int DIVISOR_W  = 2 * TOTAL_W;
	localparam int DIV_STEPS  = QUOTIENT_W;
	localparam int STEP_W     = 5;

	localparam int CLOCK_SCALE = 1000;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic REG_MIN_CLOCK = 1'b0;
	localparam logic REG_MAX_CLOCK = 1'b1;

	localparam logic [CLOCK_W-1:0] MIN_CLOCK_RESET = 20'd25000;
	localparam logic [CLOCK_W-1:0] MAX_CLOCK_RESET = 20'd600000;

	typedef struct packed {
		logic [CLOCK_W-1:0]  pixel_clock;
		logic [ACTIVE_W-1:0] h_active;
		logic [TOTAL_W-1:0]  h_total;
		logic [TOTAL_W-1:0]  h_sync_start;
		logic [TOTAL_W-1:0]  h_sync_end;
		logic [ACTIVE_W-1:0] v_active;
		logic [TOTAL_W-1:0]  v_total;
		logic [TOTAL_W-1:0]  v_sync_start;
		logic [TOTAL_W-1:0]  v_sync_end;
		logic                interlaced;
		logic                vsync_pos;
		logic                hsync_pos;
	} timing_t;

endpackage

>>> src/edtd_store_decode.sv
// ----------------------------------------------------------------------------
// EDID descriptor byte store and field decode
// Collects the 18 descriptor bytes by position and unpacks the timing fields.
// ----------------------------------------------------------------------------
module edtd_store_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [7:0]        wr_byte,
	output logic              last,
	output edtd_pkg::timing_t timing
);

	logic [7:0]                  store_q [edtd_pkg::DESCRIPTOR_LENGTH];
	logic [edtd_pkg::POS_W-1:0]  pos_q;
	logic [15:0]                 clk_word;
	logic [11:0]                 h_blank;
	logic [11:0]                 v_blank;
	logic [9:0]                  h_off;
	logic [9:0]                  h_width;
	logic [5:0]                  v_off;
	logic [5:0]                  v_width;
	logic [12:0]                 hss;
	logic [12:0]                 vss;

	assign last = wr_en &&
		(pos_q == edtd_pkg::POS_W'(edtd_pkg::DESCRIPTOR_LENGTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (wr_en) begin
			if (last) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[pos_q] <= wr_byte;
		end
	end

	always_comb begin
		clk_word = {store_q[1], store_q[0]};
		h_blank  = {store_q[4][3:0], store_q[3]};
		v_blank  = {store_q[7][3:0], store_q[6]};
		h_off    = {store_q[11][7:6], store_q[8]};
		h_width  = {store_q[11][5:4], store_q[9]};
		v_off    = {store_q[11][3:2], store_q[10][7:4]};
		v_width  = {store_q[11][1:0], store_q[10][3:0]};

		timing.pixel_clock = ({4'b0, clk_word} << 3) + ({4'b0, clk_word} << 1);
		timing.h_active    = {store_q[4][7:4], store_q[2]};
		timing.v_active    = {store_q[7][7:4], store_q[5]};
		timing.h_total     = {1'b0, timing.h_active} + {1'b0, h_blank};
		timing.v_total     = {1'b0, timing.v_active} + {1'b0, v_blank};
		hss                = {1'b0, timing.h_active} + {3'b0, h_off};
		vss                = {1'b0, timing.v_active} + {7'b0, v_off};
		timing.h_sync_start = hss;
		timing.v_sync_start = vss;
		timing.h_sync_end   = hss + {3'b0, h_width};
		timing.v_sync_end   = vss + {7'b0, v_width};
		timing.interlaced   = store_q[17][7];
		timing.vsync_pos    = store_q[17][2];
		timing.hsync_pos    = store_q[17][1];
	end

endmodule

>>> src/edtd_serial_div.sv
// ----------------------------------------------------------------------------
// EDID refresh bit-serial divider
// Restoring division producing one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module edtd_serial_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic [edtd_pkg::QUOTIENT_W-1:0]     dividend,
	input  logic [edtd_pkg::DIVISOR_W-1:0]      divisor,
	output logic                                done,
	output logic [edtd_pkg::QUOTIENT_W-1:0]     quotient
);

	logic                               active_q;
	logic                               done_q;
	logic [edtd_pkg::STEP_W-1:0]        cnt_q;
	logic [edtd_pkg::DIVISOR_W-1:0]     divisor_q;
	logic [edtd_pkg::DIVISOR_W-1:0]     rem_q;
	logic [edtd_pkg::QUOTIENT_W-1:0]    quo_q;
	logic [edtd_pkg::DIVISOR_W:0]       rem_shift;
	logic [edtd_pkg::DIVISOR_W:0]       rem_sub;
	logic                               fits;

	always_comb begin
		rem_shift = {rem_q, quo_q[edtd_pkg::QUOTIENT_W-1]};
		rem_sub   = rem_shift - {1'b0, divisor_q};
		fits      = rem_shift >= {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				active_q <= 1'b1;
				cnt_q    <= edtd_pkg::STEP_W'(edtd_pkg::DIV_STEPS - 1);
			end else if (active_q) begin
				if (cnt_q == '0) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			divisor_q <= divisor;
			rem_q     <= '0;
			quo_q     <= dividend;
		end else if (active_q) begin
			rem_q <= fits ? rem_sub[edtd_pkg::DIVISOR_W-1:0]
			              : rem_shift[edtd_pkg::DIVISOR_W-1:0];
			quo_q <= {quo_q[edtd_pkg::QUOTIENT_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> src/edid_detailed_timing_decoder.sv
// ----------------------------------------------------------------------------
// EDID detailed timing decoder
// Decodes an 18-byte detailed timing descriptor into timing values and rates.
// ----------------------------------------------------------------------------
// Usage: present one descriptor byte on descriptor_byte with start high; the
// byte is taken at a rising edge where start is high and busy is low. Bytes
// zero to sixteen are taken one per cycle while start is held. The eighteenth
// byte sets busy through the sequencer states: decode registers the fields,
// load forms the refresh products and loads the two bit-serial dividers, the
// dividers run, and the result is registered when both end. The result then
// shows on the outputs with result_valid high for a single cycle, and busy
// falls in that same cycle. The receiver cannot stall: each result beat lasts
// exactly one cycle. The lowest accepted pixel clock (address 0) and the
// highest accepted pixel clock (address 4) are to be written through the APB
// port only while the block is idle; the block itself does not enforce this.
// Reset clears the byte position, the sequencer and the result strobe and
// restores both pixel clock limits; the descriptor store itself holds no reset
// value.
// ----------------------------------------------------------------------------
module edid_detailed_timing_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [edtd_pkg::PADDR_W-1:0]      paddr,
	input  logic [edtd_pkg::PDATA_W-1:0]      pwdata,
	output logic [edtd_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	input  logic                              start,
	output logic                              busy,
	input  logic [7:0]                        descriptor_byte,
	output logic                              result_valid,
	output logic [19:0]                       pixel_clock_khz,
	output logic [11:0]                       h_active,
	output logic [12:0]                       h_total,
	output logic [12:0]                       h_sync_start,
	output logic [12:0]                       h_sync_end,
	output logic [11:0]                       v_active,
	output logic [12:0]                       v_total,
	output logic [12:0]                       v_sync_start,
	output logic [12:0]                       v_sync_end,
	output logic [29:0]                       v_refresh_hz,
	output logic [29:0]                       h_refresh_hz,
	output logic [3:0]                        mode_flags
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DECODE = 4'b0010,
		ST_LOAD   = 4'b0100,
		ST_DIV    = 4'b1000
	} state_t;

	state_t                                 state_q;
	logic [edtd_pkg::CLOCK_W-1:0]           min_clock_q;
	logic [edtd_pkg::CLOCK_W-1:0]           max_clock_q;
	logic                                   accept;
	logic                                   last;
	logic                                   cfg_wr;
	edtd_pkg::timing_t                      timing;
	edtd_pkg::timing_t                      timing_q;
	logic                                   valid_q;
	logic                                   zero_total_q;
	logic                                   mode_ok;
	logic                                   div_load;
	logic [edtd_pkg::QUOTIENT_W-1:0]        dividend;
	logic [edtd_pkg::DIVISOR_W-1:0]         frame_pixels;
	logic                                   v_done;
	logic                                   h_done;
	logic [edtd_pkg::QUOTIENT_W-1:0]        v_quo;
	logic [edtd_pkg::QUOTIENT_W-1:0]        h_quo;
	logic                                   result_valid_q;

	assign accept = start && !busy;
	assign busy   = state_q != ST_IDLE;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_clock_q <= edtd_pkg::MIN_CLOCK_RESET;
			max_clock_q <= edtd_pkg::MAX_CLOCK_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				edtd_pkg::REG_MIN_CLOCK: begin
					min_clock_q <= pwdata[edtd_pkg::CLOCK_W-1:0];
				end
				edtd_pkg::REG_MAX_CLOCK: begin
					max_clock_q <= pwdata[edtd_pkg::CLOCK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			edtd_pkg::REG_MIN_CLOCK: prdata = {12'b0, min_clock_q};
			edtd_pkg::REG_MAX_CLOCK: prdata = {12'b0, max_clock_q};
			default:                 prdata = '0;
		endcase
	end

	edtd_store_decode u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_byte (descriptor_byte),
		.last    (last),
		.timing  (timing)
	);

	always_comb begin
		mode_ok = (timing.h_active != '0) && (timing.v_active != '0) &&
			(timing.h_total > {1'b0, timing.h_active}) &&
			(timing.v_total > {1'b0, timing.v_active}) &&
			(timing.pixel_clock >= min_clock_q) &&
			(timing.pixel_clock <= max_clock_q) &&
			(timing.h_sync_start >= {1'b0, timing.h_active}) &&
			(timing.h_sync_end >= timing.h_sync_start) &&
			(timing.h_total >= timing.h_sync_end) &&
			(timing.v_sync_start >= {1'b0, timing.v_active}) &&
			(timing.v_sync_end >= timing.v_sync_start) &&
			(timing.v_total >= timing.v_sync_end);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DECODE) begin
			timing_q     <= timing;
			valid_q      <= mode_ok;
			zero_total_q <= (timing.h_total == '0) || (timing.v_total == '0);
		end
	end

	assign div_load     = state_q == ST_LOAD;
	assign dividend     = edtd_pkg::QUOTIENT_W'(timing_q.pixel_clock) *
		edtd_pkg::QUOTIENT_W'(edtd_pkg::CLOCK_SCALE);
	assign frame_pixels = edtd_pkg::DIVISOR_W'(timing_q.h_total) *
		edtd_pkg::DIVISOR_W'(timing_q.v_total);

	edtd_serial_div u_vdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.dividend (dividend),
		.divisor  (frame_pixels),
		.done     (v_done),
		.quotient (v_quo)
	);

	edtd_serial_div u_hdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.dividend (dividend),
		.divisor  (edtd_pkg::DIVISOR_W'(timing_q.h_total)),
		.done     (h_done),
		.quotient (h_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (last) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (v_done && h_done) begin
						state_q        <= ST_IDLE;
						result_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && v_done && h_done) begin
			pixel_clock_khz <= timing_q.pixel_clock;
			h_active        <= timing_q.h_active;
			h_total         <= timing_q.h_total;
			h_sync_start    <= timing_q.h_sync_start;
			h_sync_end      <= timing_q.h_sync_end;
			v_active        <= timing_q.v_active;
			v_total         <= timing_q.v_total;
			v_sync_start    <= timing_q.v_sync_start;
			v_sync_end      <= timing_q.v_sync_end;
			v_refresh_hz    <= zero_total_q ? '0 : v_quo;
			h_refresh_hz    <= zero_total_q ? '0 : h_quo;
			mode_flags      <= {valid_q, timing_q.interlaced, timing_q.vsync_pos,
				timing_q.hsync_pos};
		end
	end

	assign result_valid = result_valid_q;

	a_last_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> busy)
		else $error("last descriptor byte did not start decoding");

	a_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy && $past(state_q == ST_DIV))
		else $error("result beat outside the end of a division");

	a_zero_total_rates: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (h_total == '0 || v_total == '0) |->
			v_refresh_hz == '0 && h_refresh_hz == '0)
		else $error("nonzero refresh with a zero total");

	a_refresh_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> v_refresh_hz <= h_refresh_hz)
		else $error("vertical refresh above horizontal refresh");

endmodule
